/* src/rau_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared codes, field widths and types of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int CMD_W     = 2;
	localparam int RES_NUM_W = 32;
	localparam int RES_DEN_W = 30;

	localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SUB = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MUL = 2'd2;

	typedef struct packed {
		logic busy;
		logic done;
	} red_stat_t;

endpackage

/* src/rau_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_in_if
// Request channel: opcode and two signed fractions, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rau_in_if
	import rau_pkg::*;
#(
	parameter int OPERAND_WIDTH = 16
) ();

	logic                       valid;
	logic                       ready;
	logic [CMD_W-1:0]           cmd;
	logic [OPERAND_WIDTH-1:0]   a_num;
	logic [OPERAND_WIDTH-2:0]   a_den;
	logic [OPERAND_WIDTH-1:0]   b_num;
	logic [OPERAND_WIDTH-2:0]   b_den;

	modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
	modport sink   (input valid, cmd, a_num, a_den, b_num, b_den, output ready);

endinterface

/* src/rau_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_out_if
// Result channel: reduced fraction and compare flags, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rau_out_if
	import rau_pkg::*;
();

	logic                   valid;
	logic                   ready;
	logic [RES_NUM_W-1:0]   res_num;
	logic [RES_DEN_W-1:0]   res_den;
	logic                   is_equal;
	logic                   is_greater;
	logic                   is_less;
	logic                   bad_denominator;

	modport source (output valid, res_num, res_den, is_equal, is_greater, is_less,
		bad_denominator, input ready);
	modport sink   (input valid, res_num, res_den, is_equal, is_greater, is_less,
		bad_denominator, output ready);

endinterface

/* src/rau_reduce.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_reduce
// Puts m/d in lowest terms: binary gcd by shift and subtract, then two
// restoring divisions by the gcd, one quotient bit per cycle. A zero m
// gives 0/1.
// ----------------------------------------------------------------------------
module rau_reduce
	import rau_pkg::*;
#(
	parameter int RW = 31
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [RW-1:0]   m,
	input  logic [RW-1:0]   d,
	output red_stat_t       stat,
	output logic [RW-1:0]   q_m,
	output logic [RW-1:0]   q_d
);

	localparam int KW = $clog2(RW);

	typedef enum logic [3:0] {
		R_IDLE = 4'b0001,
		R_GCD  = 4'b0010,
		R_DIV  = 4'b0100,
		R_DONE = 4'b1000
	} red_state_t;

	red_state_t       state_q;
	logic [RW-1:0]    u_q, v_q, g_q;
	logic [KW-1:0]    k_q, cnt_q;
	logic [RW-1:0]    rm_q, rd_q, qm_q, qd_q;

	logic [RW-1:0]    u_n, v_n, diff;
	logic [KW-1:0]    k_n;
	logic             u_ge_v;
	logic [2*RW-1:0]  step_m, step_d;

	function automatic logic [2*RW-1:0] div_step(input logic [RW-1:0] rem,
		input logic [RW-1:0] dvd, input logic [RW-1:0] dsr);
		logic [RW:0] trial;
		logic [RW:0] sub;
		trial = {rem, dvd[RW-1]};
		sub   = trial - {1'b0, dsr};
		if (trial >= {1'b0, dsr}) begin
			return {sub[RW-1:0], dvd[RW-2:0], 1'b1};
		end else begin
			return {trial[RW-1:0], dvd[RW-2:0], 1'b0};
		end
	endfunction

	always_comb begin
		u_ge_v = (u_q >= v_q);
		diff   = u_ge_v ? (u_q - v_q) : (v_q - u_q);
		u_n    = u_q;
		v_n    = v_q;
		k_n    = k_q;
		if (!u_q[0] && !v_q[0]) begin
			u_n = u_q >> 1;
			v_n = v_q >> 1;
			k_n = k_q + KW'(1);
		end else if (!u_q[0]) begin
			u_n = u_q >> 1;
		end else if (!v_q[0]) begin
			v_n = v_q >> 1;
		end else if (u_ge_v) begin
			u_n = diff >> 1;
		end else begin
			v_n = diff >> 1;
		end
	end

	assign step_m = div_step(rm_q, qm_q, g_q);
	assign step_d = div_step(rd_q, qd_q, g_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
		end else begin
			case (state_q)
				R_IDLE: begin
					if (start) begin
						state_q <= (m == '0) ? R_DONE : R_GCD;
					end
				end
				R_GCD: begin
					if (u_q == '0) begin
						state_q <= R_DIV;
					end
				end
				R_DIV: begin
					if (cnt_q == '0) begin
						state_q <= R_DONE;
					end
				end
				R_DONE: state_q <= R_IDLE;
				default: state_q <= R_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			R_IDLE: begin
				if (start) begin
					u_q   <= m;
					v_q   <= d;
					k_q   <= '0;
					rm_q  <= '0;
					rd_q  <= '0;
					cnt_q <= KW'(RW - 1);
					qm_q  <= m;
					qd_q  <= (m == '0) ? RW'(1) : d;
				end
			end
			R_GCD: begin
				if (u_q == '0) begin
					g_q <= v_q << k_q;
				end else begin
					u_q <= u_n;
					v_q <= v_n;
					k_q <= k_n;
				end
			end
			R_DIV: begin
				{rm_q, qm_q} <= step_m;
				{rd_q, qd_q} <= step_d;
				cnt_q        <= cnt_q - KW'(1);
			end
			default: ;
		endcase
	end

	assign stat.busy = (state_q != R_IDLE);
	assign stat.done = (state_q == R_DONE);
	assign q_m       = qm_q;
	assign q_d       = qd_q;

	a_done_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> (qd_q != '0))
		else $error("reduced denominator is zero");

	a_gcd_v_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == R_GCD) |-> (v_q != '0))
		else $error("gcd operand collapsed to zero");

	a_start_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == R_DONE) |=> (state_q == R_IDLE))
		else $error("reduction did not return to idle");

endmodule

/* src/rational_arith_unit_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_unit_top
// Adds, subtracts or multiplies two signed fractions and returns the result
// in lowest terms, with equal/greater/less flags and a zero-denominator flag.
// ----------------------------------------------------------------------------
// One request at a time. Each operand is reduced, the four cross products
// are formed on one multiplier, and the result is reduced again, all three
// reductions on one shared gcd/divide unit (one shift-subtract or one
// quotient bit per cycle, 2*OPERAND_WIDTH-1 bits wide). The gcd takes fewer steps
// for small values, so these finish sooner; a zero denominator skips all
// reductions and goes straight to the result.
// The result waits in an output register, so the next request is taken
// while it is still held.
// ----------------------------------------------------------------------------
module rational_arith_unit_top
	import rau_pkg::*;
#(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	rau_in_if.sink      in_ch,
	rau_out_if.source   out_ch
);

	localparam int W   = OPERAND_WIDTH;
	localparam int RW  = 2 * W - 1;
	localparam int NXW = (2 * W > RES_NUM_W) ? 2 * W : RES_NUM_W;
	localparam int DXW = (RW > RES_DEN_W) ? RW : RES_DEN_W;

	localparam logic [1:0] MS_PA  = 2'd0;
	localparam logic [1:0] MS_PB  = 2'd1;
	localparam logic [1:0] MS_DEN = 2'd2;
	localparam logic [1:0] MS_PN  = 2'd3;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_RA   = 10'b0000000010,
		ST_WA   = 10'b0000000100,
		ST_RB   = 10'b0000001000,
		ST_WB   = 10'b0000010000,
		ST_MUL  = 10'b0000100000,
		ST_SUM  = 10'b0001000000,
		ST_RR   = 10'b0010000000,
		ST_WR   = 10'b0100000000,
		ST_EMIT = 10'b1000000000
	} state_t;

	state_t                  state_q;
	logic [CMD_W-1:0]        cmd_q;
	logic [W-1:0]            an_q, bn_q;
	logic [W-2:0]            ad_q, bd_q, xd_q, yd_q;
	logic                    bad_q;
	logic signed [W-1:0]     xn_q, yn_q;
	logic [1:0]              step_q;
	logic signed [2*W-1:0]   pa_q, pb_q, pn_q, num_q;
	logic [RW-1:0]           den_q;
	logic                    eq_q, gt_q, lt_q;

	logic                    ov_q;
	logic [RES_NUM_W-1:0]    onum_q;
	logic [RES_DEN_W-1:0]    oden_q;
	logic                    oeq_q, ogt_q, olt_q, obad_q;

	logic [W-1:0]            a_mag, b_mag;
	logic [2*W-1:0]          num_abs;
	logic signed [W-1:0]     mul_x, mul_y;
	logic signed [2*W-1:0]   prod;
	logic signed [2*W-1:0]   rn;
	logic signed [NXW-1:0]   rn_ext;
	logic [DXW-1:0]          rd_ext;
	logic                    red_start;
	logic [RW-1:0]           red_m, red_d, red_qm, red_qd;
	red_stat_t               red_stat;
	logic                    out_free;

	assign a_mag   = an_q[W-1] ? -an_q : an_q;
	assign b_mag   = bn_q[W-1] ? -bn_q : bn_q;
	assign num_abs = num_q[2*W-1] ? -num_q : num_q;

	always_comb begin
		red_start = 1'b0;
		red_m     = '0;
		red_d     = '0;
		case (state_q)
			ST_RA: begin
				red_start = 1'b1;
				red_m     = RW'(a_mag);
				red_d     = RW'(ad_q);
			end
			ST_RB: begin
				red_start = 1'b1;
				red_m     = RW'(b_mag);
				red_d     = RW'(bd_q);
			end
			ST_RR: begin
				red_start = 1'b1;
				red_m     = num_abs[RW-1:0];
				red_d     = den_q;
			end
			default: ;
		endcase
	end

	rau_reduce #(
		.RW (RW)
	) u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start),
		.m      (red_m),
		.d      (red_d),
		.stat   (red_stat),
		.q_m    (red_qm),
		.q_d    (red_qd)
	);

	always_comb begin
		case (step_q)
			MS_PA: begin
				mul_x = xn_q;
				mul_y = {1'b0, yd_q};
			end
			MS_PB: begin
				mul_x = yn_q;
				mul_y = {1'b0, xd_q};
			end
			MS_DEN: begin
				mul_x = {1'b0, xd_q};
				mul_y = {1'b0, yd_q};
			end
			default: begin
				mul_x = xn_q;
				mul_y = yn_q;
			end
		endcase
	end

	assign prod = mul_x * mul_y;

	assign rn       = num_q[2*W-1] ? -{1'b0, red_qm} : {1'b0, red_qm};
	assign rn_ext   = NXW'(rn);
	assign rd_ext   = DXW'(red_qd);
	assign out_free = !ov_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						state_q <= ((in_ch.a_den == '0) || (in_ch.b_den == '0)) ? ST_EMIT : ST_RA;
					end
				end
				ST_RA: state_q <= ST_WA;
				ST_WA: begin
					if (red_stat.done) begin
						state_q <= ST_RB;
					end
				end
				ST_RB: state_q <= ST_WB;
				ST_WB: begin
					if (red_stat.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (step_q == MS_PN) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: state_q <= ST_RR;
				ST_RR: state_q <= ST_WR;
				ST_WR: begin
					if (red_stat.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					cmd_q <= in_ch.cmd;
					an_q  <= in_ch.a_num;
					ad_q  <= in_ch.a_den;
					bn_q  <= in_ch.b_num;
					bd_q  <= in_ch.b_den;
					bad_q <= (in_ch.a_den == '0) || (in_ch.b_den == '0);
				end
			end
			ST_WA: begin
				xn_q <= an_q[W-1] ? -red_qm[W-1:0] : red_qm[W-1:0];
				xd_q <= red_qd[W-2:0];
			end
			ST_WB: begin
				yn_q   <= bn_q[W-1] ? -red_qm[W-1:0] : red_qm[W-1:0];
				yd_q   <= red_qd[W-2:0];
				step_q <= MS_PA;
			end
			ST_MUL: begin
				case (step_q)
					MS_PA:   pa_q  <= prod;
					MS_PB:   pb_q  <= prod;
					MS_DEN:  den_q <= prod[RW-1:0];
					default: pn_q  <= prod;
				endcase
				step_q <= step_q + 2'd1;
			end
			ST_SUM: begin
				case (cmd_q)
					CMD_ADD: num_q <= pa_q + pb_q;
					CMD_SUB: num_q <= pa_q - pb_q;
					CMD_MUL: num_q <= pn_q;
					default: num_q <= pn_q;
				endcase
				eq_q <= (xn_q == yn_q) && (xd_q == yd_q);
				gt_q <= (pa_q > pb_q);
				lt_q <= (pa_q < pb_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && out_free) begin
			ov_q <= 1'b1;
		end else if (out_ch.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			if (bad_q) begin
				onum_q <= '0;
				oden_q <= '0;
				oeq_q  <= 1'b0;
				ogt_q  <= 1'b0;
				olt_q  <= 1'b0;
				obad_q <= 1'b1;
			end else begin
				onum_q <= rn_ext[RES_NUM_W-1:0];
				oden_q <= rd_ext[RES_DEN_W-1:0];
				oeq_q  <= eq_q;
				ogt_q  <= gt_q;
				olt_q  <= lt_q;
				obad_q <= 1'b0;
			end
		end
	end

	assign in_ch.ready            = (state_q == ST_IDLE);
	assign out_ch.valid           = ov_q;
	assign out_ch.res_num         = onum_q;
	assign out_ch.res_den         = oden_q;
	assign out_ch.is_equal        = oeq_q;
	assign out_ch.is_greater      = ogt_q;
	assign out_ch.is_less         = olt_q;
	assign out_ch.bad_denominator = obad_q;

	a_ready_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !red_stat.busy)
		else $error("request taken while reduction unit busy");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !(out_ch.is_greater && out_ch.is_less))
		else $error("greater and less both set");

	a_equal_no_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.is_equal) |-> (!out_ch.is_greater && !out_ch.is_less))
		else $error("equal operands reported as ordered");

	a_bad_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.bad_denominator) |->
		((out_ch.res_den == '0) && (out_ch.res_num == '0)))
		else $error("zero denominator with nonzero result");

endmodule

/* test/tb_rational_arith_unit_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_arith_unit_top
// Self-checking bench for the rational arithmetic unit. A table of directed
// requests covers zero denominators, zero results, operand extremes, the
// unused opcode and equal operands. Random requests follow, with random
// stalls on both channels, one long result-side hold-off and one drain pause.
// Each result is checked in request order against the table or a fraction predictor.
// ----------------------------------------------------------------------------
module tb_rational_arith_unit_top;
	import rau_pkg::*;

	localparam int OW             = 16;
	localparam int RAND_ITEMS     = 2000;
	localparam int HOLD_CYCLES    = 2000;
	localparam int DRAIN_CYCLES   = 400;
	localparam int WATCHDOG_LIMIT = 20000;

	localparam logic [CMD_W-1:0] CMD_RSVD = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [OW-1:0]    a_num;
		logic [OW-2:0]    a_den;
		logic [OW-1:0]    b_num;
		logic [OW-2:0]    b_den;
	} req_t;

	typedef struct packed {
		logic [RES_NUM_W-1:0] res_num;
		logic [RES_DEN_W-1:0] res_den;
		logic                 is_equal;
		logic                 is_greater;
		logic                 is_less;
		logic                 bad_denominator;
	} res_t;

	typedef struct packed {
		req_t r;
		bit   typed;
		res_t e;
	} row_t;

	logic clk;
	logic arst_n;

	row_t stim_table[$];
	res_t pending_results[$];
	int   n_errors     = 0;
	int   stall_cycles = 0;
	bit   calm         = 1'b0;
	bit   hold_req     = 1'b0;

	rau_in_if #(.OPERAND_WIDTH(OW)) in_ch ();
	rau_out_if out_ch ();

	rational_arith_unit_top #(.OPERAND_WIDTH(OW)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint unsigned euclid_gcd(input longint unsigned x,
		input longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// Reduce n/d with d > 0; a zero numerator becomes 0/1.
	function automatic void lowest_terms(input longint n, input longint unsigned d,
		output longint rn, output longint unsigned rd);
		longint unsigned mag;
		longint unsigned g;
		if (n < 0)
			mag = -n;
		else
			mag = n;
		if (mag == 0) begin
			rn = 0;
			rd = 1;
			return;
		end
		g   = euclid_gcd(mag, d);
		mag = mag / g;
		rd  = d / g;
		if (n < 0)
			rn = -longint'(mag);
		else
			rn = longint'(mag);
	endfunction

	function automatic res_t rational_result(input req_t r);
		res_t            o;
		longint          xn, yn, pa, pb, num, rn;
		longint unsigned xd, yd, den, rd;
		o = '0;
		if (r.a_den == 0 || r.b_den == 0) begin
			o.bad_denominator = 1'b1;
			return o;
		end
		lowest_terms(longint'($signed(r.a_num)), 64'(r.a_den), xn, xd);
		lowest_terms(longint'($signed(r.b_num)), 64'(r.b_den), yn, yd);
		pa  = xn * longint'(yd);
		pb  = yn * longint'(xd);
		den = xd * yd;
		if (r.cmd == CMD_MUL || r.cmd == CMD_RSVD)
			num = xn * yn;
		else if (r.cmd == CMD_SUB)
			num = pa - pb;
		else
			num = pa + pb;
		lowest_terms(num, den, rn, rd);
		o.res_num    = rn[RES_NUM_W-1:0];
		o.res_den    = rd[RES_DEN_W-1:0];
		o.is_equal   = (xn == yn) && (xd == yd);
		o.is_greater = pa > pb;
		o.is_less    = pa < pb;
		return o;
	endfunction

	function automatic void put_row(input logic [CMD_W-1:0] c, input int an, input int ad,
		input int bn, input int bd, input bit typed = 1'b0, input longint en = 0,
		input longint ed = 0, input bit eq = 1'b0, input bit gt = 1'b0,
		input bit lt = 1'b0, input bit bad = 1'b0);
		row_t row;
		row.r.cmd             = c;
		row.r.a_num           = an[OW-1:0];
		row.r.a_den           = ad[OW-2:0];
		row.r.b_num           = bn[OW-1:0];
		row.r.b_den           = bd[OW-2:0];
		row.typed             = typed;
		row.e.res_num         = en[RES_NUM_W-1:0];
		row.e.res_den         = ed[RES_DEN_W-1:0];
		row.e.is_equal        = eq;
		row.e.is_greater      = gt;
		row.e.is_less         = lt;
		row.e.bad_denominator = bad;
		stim_table.push_back(row);
	endfunction

	function automatic logic [OW-1:0] random_num();
		int pick;
		int v;
		pick = $urandom_range(99);
		if (pick < 40)
			v = $urandom;
		else if (pick < 75)
			v = int'($urandom_range(40)) - 20;
		else if (pick < 92)
			v = (int'($urandom_range(24)) - 12) << $urandom_range(10);
		else
			case ($urandom_range(3))
				0: v = -32768;
				1: v = 32767;
				2: v = -1;
				default: v = 0;
			endcase
		return v[OW-1:0];
	endfunction

	function automatic logic [OW-2:0] random_den();
		int pick;
		int v;
		pick = $urandom_range(99);
		if (pick < 4)
			v = 0;
		else if (pick < 44)
			v = $urandom_range(1, 24);
		else if (pick < 56)
			v = $urandom_range(1, 24) << $urandom_range(10);
		else
			v = $urandom_range(1, 32767);
		return v[OW-2:0];
	endfunction

	function automatic req_t random_req();
		req_t r;
		r.cmd   = CMD_W'($urandom_range(3));
		r.a_num = random_num();
		r.a_den = random_den();
		if ($urandom_range(99) < 8) begin
			r.b_num = r.a_num;
			r.b_den = r.a_den;
		end else begin
			r.b_num = random_num();
			r.b_den = random_den();
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		n_errors++;
		$display("%0t ns: %s got %0d, want %0d", $time, what, got, want);
	endtask

	task automatic send_req(input req_t r, input bit typed, input res_t e);
		while (!calm && $urandom_range(99) < 29) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd   <= r.cmd;
		in_ch.a_num <= r.a_num;
		in_ch.a_den <= r.a_den;
		in_ch.b_num <= r.b_num;
		in_ch.b_den <= r.b_den;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		pending_results.push_back(typed ? e : rational_result(r));
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin
		bit held;
		held         = 1'b0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 29);
		end
	end

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.res_num         = out_ch.res_num;
			got.res_den         = out_ch.res_den;
			got.is_equal        = out_ch.is_equal;
			got.is_greater      = out_ch.is_greater;
			got.is_less         = out_ch.is_less;
			got.bad_denominator = out_ch.bad_denominator;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, res_num",
					longint'($signed(got.res_num)), 0);
			end else begin
				want = pending_results.pop_front();
				if (got.res_num !== want.res_num)
					report_mismatch("res_num", longint'($signed(got.res_num)),
						longint'($signed(want.res_num)));
				if (got.res_den !== want.res_den)
					report_mismatch("res_den", longint'(got.res_den),
						longint'(want.res_den));
				if (got.is_equal !== want.is_equal)
					report_mismatch("is_equal", longint'(got.is_equal),
						longint'(want.is_equal));
				if (got.is_greater !== want.is_greater)
					report_mismatch("is_greater", longint'(got.is_greater),
						longint'(want.is_greater));
				if (got.is_less !== want.is_less)
					report_mismatch("is_less", longint'(got.is_less),
						longint'(want.is_less));
				if (got.bad_denominator !== want.bad_denominator)
					report_mismatch("bad_denominator", longint'(got.bad_denominator),
						longint'(want.bad_denominator));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		req_t r;
		arst_n       <= 1'b0;
		in_ch.valid  <= 1'b0;
		in_ch.cmd    <= CMD_ADD;
		in_ch.a_num  <= '0;
		in_ch.a_den  <= '0;
		in_ch.b_num  <= '0;
		in_ch.b_den  <= '0;

		// zero denominators
		put_row(CMD_ADD, 5, 0, 3, 4, 1, 0, 0, 0, 0, 0, 1);
		put_row(CMD_SUB, 1, 1, -7, 0, 1, 0, 0, 0, 0, 0, 1);
		put_row(CMD_MUL, -32768, 0, 32767, 0, 1, 0, 0, 0, 0, 0, 1);
		// zero results and equal operands
		put_row(CMD_ADD, 0, 5, 0, 9, 1, 0, 1, 1, 0, 0, 0);
		put_row(CMD_SUB, 3, 4, 3, 4, 1, 0, 1, 1, 0, 0, 0);
		put_row(CMD_SUB, 5, 10, 1, 2, 1, 0, 1, 1, 0, 0, 0);
		put_row(CMD_ADD, 1, 2, -1, 2, 1, 0, 1, 0, 1, 0, 0);
		put_row(CMD_MUL, 0, 7, -5, 3, 1, 0, 1, 0, 1, 0, 0);
		put_row(CMD_ADD, 1, 1, 1, 1, 1, 2, 1, 1, 0, 0, 0);
		put_row(CMD_ADD, 6, 4, 3, 2, 1, 3, 1, 1, 0, 0, 0);
		put_row(CMD_ADD, 12, 18, 10, 15, 1, 4, 3, 1, 0, 0, 0);
		// operand extremes
		put_row(CMD_MUL, -32768, 1, -32768, 1, 1, 1073741824, 1, 1, 0, 0, 0);
		put_row(CMD_ADD, 32767, 1, 32767, 1, 1, 65534, 1, 1, 0, 0, 0);
		put_row(CMD_SUB, -32768, 1, 32767, 1, 1, -65535, 1, 0, 0, 1, 0);
		put_row(CMD_SUB, 32767, 1, -32768, 1, 1, 65535, 1, 0, 1, 0, 0);
		put_row(CMD_MUL, 1, 32767, -1, 32767, 1, -1, 1073676289, 0, 1, 0, 0);
		put_row(CMD_ADD, -32768, 32767, 0, 1, 1, -32768, 32767, 0, 0, 1, 0);
		put_row(CMD_ADD, 1, 32767, 1, 32766);
		put_row(CMD_MUL, 32767, 32767, -32768, 32767);
		put_row(CMD_SUB, -32768, 32767, 32767, 32766);
		put_row(CMD_ADD, -32768, 32767, -32768, 32767);
		put_row(CMD_MUL, 32767, 2, 32767, 3);
		// unused opcode decodes as multiply
		put_row(CMD_RSVD, 2, 3, 3, 4, 1, 1, 2, 0, 0, 1, 0);
		put_row(CMD_RSVD, -21, 32767, 32767, 12);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i])
			send_req(stim_table[i].r, stim_table[i].typed, stim_table[i].e);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			calm = (i >= 800 && i < 1100);
			if (i == 400)
				hold_req = 1'b1;
			if (i == 1500) begin
				// drain: hold off until every result is back
				in_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			r = random_req();
			send_req(r, 1'b0, '0);
		end
		in_ch.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* rational_arith_unit_top.f */
src/rau_pkg.sv
src/rau_in_if.sv
src/rau_out_if.sv
src/rau_reduce.sv
src/rational_arith_unit_top.sv
test/tb_rational_arith_unit_top.sv
